FILE: rtl/core/price_level_order_book_defines.svh
// Assertion macros for the price level order book checker.
// Depends on nothing; the including module must have i_clk and i_rst_n.
`ifndef PRICE_LEVEL_ORDER_BOOK_DEFINES_SVH
`define PRICE_LEVEL_ORDER_BOOK_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLOB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("order book check failed");

// The consequent must hold in the cycle after the antecedent.
`define PLOB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("order book check failed");

// The consequent must hold at a later edge than the antecedent.
`define PLOB_ASSERT_THREE(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##3 (cons)) else $error("order book check failed");

`endif

FILE: rtl/core/plob_pkg.sv
// Shared types and constants of the price level order book.
// Depends on nothing; used by every module of the block.
package plob_pkg;

    localparam int PRICE_W     = 32;
    localparam int VOL_W       = 32;
    localparam int LEVEL_CNT_W = 5;
    localparam int LEVELS_DEF  = 16;
    localparam int WIDE_W      = PRICE_W + 1;

    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_CLEAR  = 1'b1;
    localparam logic SIDE_ASK    = 1'b0;
    localparam logic SIDE_BID    = 1'b1;

    // One price level as held in a cell.
    typedef struct packed {
        logic               valid;
        logic [PRICE_W-1:0] price;
        logic [VOL_W-1:0]   volume;
    } t_level;

    // Command broadcast to every cell of one side during the apply cycle.
    typedef struct packed {
        logic               clear;
        logic               ins;
        logic               rem;
        logic               upd;
        logic [PRICE_W-1:0] price;
        logic [VOL_W-1:0]   volume;
    } t_plob_ctl;

endpackage

FILE: rtl/core/plob_cell.sv
// One cell of a sorted price level row: holds one level and its compare flags.
// Depends on plob_pkg.
module plob_cell #(
    parameter bit DESC = 1'b1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmp,
    input  logic [plob_pkg::PRICE_W-1:0] i_cmp_price,
    input  plob_pkg::t_plob_ctl         i_ctl,
    input  plob_pkg::t_level            i_prev,
    input  logic                        i_prev_after,
    input  plob_pkg::t_level            i_next,
    output plob_pkg::t_level            o_level,
    output logic                        o_eq,
    output logic                        o_after
);
    import plob_pkg::*;

    t_level r_level;
    t_level n_level;
    logic   r_eq;
    logic   r_after;
    logic   w_past;

    // The cell lies strictly past the incoming price in book order.
    assign w_past = DESC ? (r_level.price < i_cmp_price) : (r_level.price > i_cmp_price);

    always_comb begin
        n_level = r_level;
        if (i_ctl.clear) begin
            n_level.valid = 1'b0;
        end else if (i_ctl.rem && (r_eq || r_after)) begin
            n_level = i_next;
        end else if (i_ctl.ins && r_after) begin
            if (i_prev_after) begin
                n_level = i_prev;
            end else begin
                n_level.valid  = 1'b1;
                n_level.price  = i_ctl.price;
                n_level.volume = i_ctl.volume;
            end
        end else if (i_ctl.upd && r_eq) begin
            n_level.volume = i_ctl.volume;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level.valid <= 1'b0;
            r_eq          <= 1'b0;
            r_after       <= 1'b0;
        end else begin
            r_level <= n_level;
            if (i_cmp) begin
                r_eq    <= r_level.valid && (r_level.price == i_cmp_price);
                r_after <= !r_level.valid || w_past;
            end
        end
    end

    assign o_level = r_level;
    assign o_eq    = r_eq;
    assign o_after = r_after;

endmodule

FILE: rtl/core/plob_side.sv
// One side of the book: a row of sorted cells, its level count and drop flag.
// Depends on plob_pkg and plob_cell.
module plob_side #(
    parameter int LEVELS = plob_pkg::LEVELS_DEF,
    parameter bit DESC   = 1'b1,
    localparam int CW    = $clog2(LEVELS + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmp,
    input  logic [plob_pkg::PRICE_W-1:0] i_cmp_price,
    input  logic                        i_apply,
    input  logic                        i_clear,
    input  logic [plob_pkg::PRICE_W-1:0] i_price,
    input  logic [plob_pkg::VOL_W-1:0]   i_volume,
    output plob_pkg::t_level            o_head,
    output logic [CW-1:0]               o_count,
    output logic                        o_drop
);
    import plob_pkg::*;

    t_level    w_level     [LEVELS];
    t_level    w_prev      [LEVELS];
    t_level    w_next      [LEVELS];
    logic      w_prev_after[LEVELS];
    logic [LEVELS-1:0] w_eq;
    logic [LEVELS-1:0] w_after;
    t_plob_ctl w_ctl;
    logic      w_match;
    logic      w_full;
    logic      w_vol_zero;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    assign w_match    = |w_eq;
    assign w_full     = w_level[LEVELS-1].valid;
    assign w_vol_zero = (i_volume == '0);

    always_comb begin
        w_ctl.clear  = i_clear;
        w_ctl.ins    = i_apply && !w_match && !w_vol_zero && !w_full;
        w_ctl.rem    = i_apply && w_match && w_vol_zero;
        w_ctl.upd    = i_apply && w_match && !w_vol_zero;
        w_ctl.price  = i_price;
        w_ctl.volume = i_volume;
    end

    genvar g;
    generate
        for (g = 0; g < LEVELS; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign w_prev[g]       = '0;
                assign w_prev_after[g] = 1'b0;
            end else begin : g_mid
                assign w_prev[g]       = w_level[g-1];
                assign w_prev_after[g] = w_after[g-1];
            end
            if (g == LEVELS - 1) begin : g_last
                assign w_next[g] = '0;
            end else begin : g_inner
                assign w_next[g] = w_level[g+1];
            end

            plob_cell #(
                .DESC(DESC)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_cmp       (i_cmp),
                .i_cmp_price (i_cmp_price),
                .i_ctl       (w_ctl),
                .i_prev      (w_prev[g]),
                .i_prev_after(w_prev_after[g]),
                .i_next      (w_next[g]),
                .o_level     (w_level[g]),
                .o_eq        (w_eq[g]),
                .o_after     (w_after[g])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (w_ctl.clear) begin
            n_count = '0;
        end else if (w_ctl.ins) begin
            n_count = r_count + CW'(1);
        end else if (w_ctl.rem) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_head  = w_level[0];
    assign o_count = r_count;
    assign o_drop  = i_apply && !w_match && !w_vol_zero && w_full;

endmodule

FILE: rtl/core/price_level_order_book.sv
// Price level order book. A word is taken when start is high and busy is low;
// its result appears on the o_ ports after r_busy and r_pend, marked by o_done.
// A compare cycle in every cell, then an apply cycle; busy covers only apply.
// The receiver cannot stall. Reset (i_rst_n low, synchronous) empties both
// sides at once through per-cell valid bits; no clearing pass is needed.
module price_level_order_book #(
    parameter int LEVELS = plob_pkg::LEVELS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_mode,
    input  logic                            i_side_bid,
    input  logic [plob_pkg::PRICE_W-1:0]    i_level_price,
    input  logic [plob_pkg::VOL_W-1:0]      i_level_volume,
    output logic                            o_done,
    output logic                            o_bid_valid,
    output logic [plob_pkg::PRICE_W-1:0]    o_top_bid,
    output logic                            o_ask_valid,
    output logic [plob_pkg::PRICE_W-1:0]    o_top_ask,
    output logic signed [plob_pkg::WIDE_W-1:0] o_quote_spread,
    output logic [plob_pkg::WIDE_W-1:0]     o_mid_half_ticks,
    output logic [plob_pkg::LEVEL_CNT_W-1:0] o_bid_levels,
    output logic [plob_pkg::LEVEL_CNT_W-1:0] o_ask_levels,
    output logic                            o_dropped_full
);
    import plob_pkg::*;

    localparam int CW = $clog2(LEVELS + 1);

    // Item capture and sequencing. The accept edge also latches the compare
    // flags in every cell against the incoming price; the following cycle
    // (r_busy high) applies the change, and the cycle after that loads the
    // result registers from the heads of both rows.
    logic               r_busy;
    logic               r_pend;
    logic               r_mode;
    logic               r_side;
    logic [PRICE_W-1:0] r_price;
    logic [VOL_W-1:0]   r_volume;
    logic               r_drop;
    logic               w_accept;
    logic               w_bid_apply;
    logic               w_ask_apply;
    logic               w_clear;
    logic               w_bid_drop;
    logic               w_ask_drop;
    t_level             w_bid_head;
    t_level             w_ask_head;
    logic [CW-1:0]      w_bid_cnt;
    logic [CW-1:0]      w_ask_cnt;
    logic [PRICE_W-1:0] w_bid_px;
    logic [PRICE_W-1:0] w_ask_px;
    logic               w_both;

    assign w_accept    = start && !r_busy;
    assign busy        = r_busy;
    assign w_clear     = r_busy && (r_mode == MODE_CLEAR);
    assign w_bid_apply = r_busy && (r_mode == MODE_UPDATE) && (r_side == SIDE_BID);
    assign w_ask_apply = r_busy && (r_mode == MODE_UPDATE) && (r_side == SIDE_ASK);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode   <= i_mode;
            r_side   <= i_side_bid;
            r_price  <= i_level_price;
            r_volume <= i_level_volume;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pend <= 1'b0;
            r_drop <= 1'b0;
        end else begin
            r_busy <= w_accept;
            r_pend <= r_busy;
            if (r_busy) begin
                r_drop <= w_bid_drop || w_ask_drop;
            end
        end
    end

    // Bids are kept highest price first, asks lowest price first.
    plob_side #(
        .LEVELS(LEVELS),
        .DESC  (1'b1)
    ) u_bid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmp      (w_accept),
        .i_cmp_price(i_level_price),
        .i_apply    (w_bid_apply),
        .i_clear    (w_clear),
        .i_price    (r_price),
        .i_volume   (r_volume),
        .o_head     (w_bid_head),
        .o_count    (w_bid_cnt),
        .o_drop     (w_bid_drop)
    );

    plob_side #(
        .LEVELS(LEVELS),
        .DESC  (1'b0)
    ) u_ask (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmp      (w_accept),
        .i_cmp_price(i_level_price),
        .i_apply    (w_ask_apply),
        .i_clear    (w_clear),
        .i_price    (r_price),
        .i_volume   (r_volume),
        .o_head     (w_ask_head),
        .o_count    (w_ask_cnt),
        .o_drop     (w_ask_drop)
    );

    // Top of book reads as zero for an empty side; spread and mid are zero
    // unless both sides hold at least one level.
    assign w_bid_px = w_bid_head.valid ? w_bid_head.price : '0;
    assign w_ask_px = w_ask_head.valid ? w_ask_head.price : '0;
    assign w_both   = w_bid_head.valid && w_ask_head.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            o_bid_valid      <= w_bid_head.valid;
            o_top_bid        <= w_bid_px;
            o_ask_valid      <= w_ask_head.valid;
            o_top_ask        <= w_ask_px;
            o_quote_spread   <= w_both ? signed'({1'b0, w_ask_px} - {1'b0, w_bid_px}) : '0;
            o_mid_half_ticks <= w_both ? ({1'b0, w_ask_px} + {1'b0, w_bid_px}) : '0;
            o_bid_levels     <= LEVEL_CNT_W'(w_bid_cnt);
            o_ask_levels     <= LEVEL_CNT_W'(w_ask_cnt);
            o_dropped_full   <= r_drop;
        end
    end

endmodule

FILE: rtl/core/plob_checker.sv
// Port-level checks of the price level order book, bound to the top level.
// Depends on plob_pkg and price_level_order_book_defines.svh.
`include "price_level_order_book_defines.svh"

module plob_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             o_done,
    input logic                             o_bid_valid,
    input logic                             o_ask_valid,
    input logic signed [plob_pkg::WIDE_W-1:0] o_quote_spread,
    input logic [plob_pkg::WIDE_W-1:0]      o_mid_half_ticks,
    input logic [plob_pkg::LEVEL_CNT_W-1:0] o_bid_levels
);
    import plob_pkg::*;

    // Every accepted word is followed by its result strobe.
    `PLOB_ASSERT_THREE(a_result_follows, start && !busy, o_done)
    // Result strobes never come back to back.
    `PLOB_ASSERT_NEXT(a_done_spaced, o_done, !o_done)
    // Accepting a word makes the block busy for the apply cycle.
    `PLOB_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy)
    // A one-sided book reports no spread and no mid price.
    `PLOB_ASSERT_NOW(a_one_sided_zero, o_done && !(o_bid_valid && o_ask_valid),
        (o_quote_spread == '0) && (o_mid_half_ticks == '0))
    // The bid flag agrees with the bid level count.
    `PLOB_ASSERT_NOW(a_bid_flag_count, o_done, o_bid_valid == (o_bid_levels != '0))

endmodule

bind price_level_order_book plob_checker u_plob_checker (.*);
